[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the point unit RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

[src/mxz_pkg.sv]
// ----------------------------------------------------------------------------
// mxz_pkg
// Constants, codes and the micro-program of the X/Z point unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mxz_pkg;

  // Field and limb geometry.
  localparam int LIMB_W = 51;
  localparam int NLIMB  = 5;
  localparam int FE_W   = 255;

  // Input command codes.
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DBL  = 2'd2;

  // The prime 2^255 - 19 and the doubling constant.
  localparam logic [FE_W-1:0] PRIME = {{247{1'b1}}, 8'hED};
  localparam logic [FE_W-1:0] A24   = FE_W'(121666);

  // Field element register file entries.
  localparam logic [3:0] FE_PU = 4'd0;
  localparam logic [3:0] FE_PW = 4'd1;
  localparam logic [3:0] FE_QU = 4'd2;
  localparam logic [3:0] FE_QW = 4'd3;
  localparam logic [3:0] FE_DU = 4'd4;
  localparam logic [3:0] FE_DW = 4'd5;
  localparam logic [3:0] FE_V0 = 4'd6;
  localparam logic [3:0] FE_V1 = 4'd7;
  localparam logic [3:0] FE_V2 = 4'd8;
  localparam logic [3:0] FE_V3 = 4'd9;
  localparam logic [3:0] FE_V4 = 4'd10;
  localparam logic [3:0] FE_RU = 4'd11;
  localparam logic [3:0] FE_RW = 4'd12;
  // Never stored: selecting it as the second operand gives the constant.
  localparam logic [3:0] FE_K  = 4'd13;
  localparam int         FE_DEPTH = 16;

  // Entry points of the two programs.
  localparam logic [4:0] PC_ADD = 5'd0;
  localparam logic [4:0] PC_DBL = 5'd12;

  typedef enum logic [1:0] {
    UOP_ADD,
    UOP_SUB,
    UOP_MUL
  } uop_kind_e;

  typedef struct packed {
    uop_kind_e  kind;
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic [3:0] dst;
    logic       last;
  } uop_t;

  function automatic uop_t mk_uop(uop_kind_e kind, logic [3:0] a, logic [3:0] b,
                                  logic [3:0] d, logic last);
    uop_t u;
    u.kind  = kind;
    u.src_a = a;
    u.src_b = b;
    u.dst   = d;
    u.last  = last;
    return u;
  endfunction

  // Micro-program: differential add from PC_ADD, doubling from PC_DBL.
  function automatic uop_t uop_rom(logic [4:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:    u = mk_uop(UOP_ADD, FE_PU, FE_PW, FE_V0, 1'b0);
      5'd1:    u = mk_uop(UOP_SUB, FE_QU, FE_QW, FE_V1, 1'b0);
      5'd2:    u = mk_uop(UOP_MUL, FE_V1, FE_V0, FE_V1, 1'b0);
      5'd3:    u = mk_uop(UOP_SUB, FE_PU, FE_PW, FE_V0, 1'b0);
      5'd4:    u = mk_uop(UOP_ADD, FE_QU, FE_QW, FE_V2, 1'b0);
      5'd5:    u = mk_uop(UOP_MUL, FE_V2, FE_V0, FE_V2, 1'b0);
      5'd6:    u = mk_uop(UOP_ADD, FE_V1, FE_V2, FE_V3, 1'b0);
      5'd7:    u = mk_uop(UOP_MUL, FE_V3, FE_V3, FE_V3, 1'b0);
      5'd8:    u = mk_uop(UOP_SUB, FE_V1, FE_V2, FE_V4, 1'b0);
      5'd9:    u = mk_uop(UOP_MUL, FE_V4, FE_V4, FE_V4, 1'b0);
      5'd10:   u = mk_uop(UOP_MUL, FE_DW, FE_V3, FE_RU, 1'b0);
      5'd11:   u = mk_uop(UOP_MUL, FE_DU, FE_V4, FE_RW, 1'b1);
      5'd12:   u = mk_uop(UOP_ADD, FE_PU, FE_PW, FE_V1, 1'b0);
      5'd13:   u = mk_uop(UOP_MUL, FE_V1, FE_V1, FE_V1, 1'b0);
      5'd14:   u = mk_uop(UOP_SUB, FE_PU, FE_PW, FE_V2, 1'b0);
      5'd15:   u = mk_uop(UOP_MUL, FE_V2, FE_V2, FE_V2, 1'b0);
      5'd16:   u = mk_uop(UOP_MUL, FE_V1, FE_V2, FE_RU, 1'b0);
      5'd17:   u = mk_uop(UOP_SUB, FE_V1, FE_V2, FE_V1, 1'b0);
      5'd18:   u = mk_uop(UOP_MUL, FE_V1, FE_K,  FE_V3, 1'b0);
      5'd19:   u = mk_uop(UOP_ADD, FE_V3, FE_V2, FE_V3, 1'b0);
      5'd20:   u = mk_uop(UOP_MUL, FE_V1, FE_V3, FE_RW, 1'b1);
      default: u = mk_uop(UOP_ADD, FE_V0, FE_V0, FE_V0, 1'b1);
    endcase
    return u;
  endfunction

endpackage

[src/mxz_ram.sv]
// ----------------------------------------------------------------------------
// mxz_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mxz_ram #(
  parameter int WIDTH = 51,
  parameter int DEPTH = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[src/montgomery_xz_point_add_double_core.sv]
// ----------------------------------------------------------------------------
// montgomery_xz_point_add_double_core
// Curve25519 X/Z differential add and doubling on one shared multiplier.
// ----------------------------------------------------------------------------
// Use: the input stream carries commands. tuser holds the op code: a load
// writes one 51-bit limb of an operand slot (P.u, P.w, Q.u, Q.w, diff.u,
// diff.w). A differential add or a doubling command reads all six slots,
// reduces them modulo 2^255-19, runs its micro-program and then sends
// R.u then R.w as ten canonical limbs on the output stream, tuser giving
// the coordinate and tlast marking the tenth limb.
// Operand read-in fetches the six slots limb by limb. Each field multiply
// forms 64 partial products on the single 32x32 multiplier, then reduces;
// each add or subtract uses the wide adder and a fold. Result limbs are
// sent one per cycle while the receiver accepts them.
// The input is not ready while a command runs or its limbs are sent.
// If the receiver stalls, the current limb is held and the unit waits.
// Reset returns the sequencer to idle; operand slots are undefined until
// loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module montgomery_xz_point_add_double_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command input.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // slot[2:0], limb_index[5:3], value[56:6]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  // Result output.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // limb_number[2:0], limb_value[53:3]
  output logic        m_axis_tuser_o,   // coordinate[0]
  output logic        m_axis_tlast_o    // last
);

  localparam int LW = mxz_pkg::LIMB_W;
  localparam int FW = mxz_pkg::FE_W;
  localparam int XW = FW + 7;
  localparam int LRAM_DEPTH = 30;
  localparam logic [2:0] LAST_LIMB = 3'(mxz_pkg::NLIMB - 1);
  localparam logic [2:0] LAST_SLOT = 3'd5;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_LOAD   = 13'b0000000000010,
    S_FETCH  = 13'b0000000000100,
    S_ARITH  = 13'b0000000001000,
    S_MUL    = 13'b0000000010000,
    S_MDRAIN = 13'b0000000100000,
    S_MTAIL  = 13'b0000001000000,
    S_RED    = 13'b0000010000000,
    S_FOLD   = 13'b0000100000000,
    S_WB     = 13'b0001000000000,
    S_EFETCH = 13'b0010000000000,
    S_ELOAD  = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } state_e;

  function automatic logic [4:0] limb_addr(logic [2:0] s, logic [2:0] l);
    return ({2'b00, s} << 2) + {2'b00, s} + {2'b00, l};
  endfunction

  // Input unpacking.
  logic [1:0]    in_op;
  logic [2:0]    in_slot;
  logic [2:0]    in_limb;
  logic [LW-1:0] in_value;
  logic          s_fire;
  logic          m_fire;
  logic          load_ok;

  assign in_op    = s_axis_tuser_i;
  assign in_slot  = s_axis_tdata_i[2:0];
  assign in_limb  = s_axis_tdata_i[5:3];
  assign in_value = s_axis_tdata_i[56:6];
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire   = m_axis_tvalid_o && m_axis_tready_i;
  assign load_ok  = (in_op == mxz_pkg::OP_LOAD) && (in_slot <= LAST_SLOT) &&
                    (in_limb <= LAST_LIMB);

  // Sequencer and control registers.
  state_e     state_q, state_d;
  logic [4:0] pc_q;
  logic [2:0] iss_slot_q, iss_limb_q;
  logic       iss_on_q;
  logic       ld_vld_q;
  logic [2:0] ld_slot_q, ld_limb_q;
  logic [3:0] k_q;
  logic [2:0] i_q;
  logic       p_vld_q, p_end_q;
  logic [1:0] red_cnt_q;
  logic       fold_cnt_q;
  logic       em_coord_q;
  logic [2:0] em_limb_q;

  // Datapath registers.
  logic [LW-1:0]       asm_q [mxz_pkg::NLIMB-1];
  logic [63:0]         p_q;
  logic [71:0]         acc_q;
  logic [511:0]        t_q;
  logic [XW-1:0]       x_q;
  logic [2*FW-1:0]     out_sr_q;

  mxz_pkg::uop_t uop;
  assign uop = mxz_pkg::uop_rom(pc_q);

  // Operand limb store.
  logic          lram_re;
  logic [4:0]    lram_raddr;
  logic [LW-1:0] lram_rdata;

  assign lram_re    = (state_q == S_LOAD) && iss_on_q;
  assign lram_raddr = limb_addr(iss_slot_q, iss_limb_q);

  mxz_ram #(.WIDTH(LW), .DEPTH(LRAM_DEPTH)) u_limb_ram (
    .clk_i   (clk_i),
    .we_i    (s_fire && load_ok),
    .waddr_i (limb_addr(in_slot, in_limb)),
    .wdata_i (in_value),
    .re_i    (lram_re),
    .raddr_i (lram_raddr),
    .rdata_o (lram_rdata)
  );

  // Field element register file, duplicated for two read ports.
  logic          fe_we, fe_re;
  logic [3:0]    fe_waddr, fe_raddr_a, fe_raddr_b;
  logic [FW-1:0] fe_wdata, fe_rdata_a, fe_rdata_b;

  mxz_ram #(.WIDTH(FW), .DEPTH(mxz_pkg::FE_DEPTH)) u_fe_ram_a (
    .clk_i   (clk_i),
    .we_i    (fe_we),
    .waddr_i (fe_waddr),
    .wdata_i (fe_wdata),
    .re_i    (fe_re),
    .raddr_i (fe_raddr_a),
    .rdata_o (fe_rdata_a)
  );

  mxz_ram #(.WIDTH(FW), .DEPTH(mxz_pkg::FE_DEPTH)) u_fe_ram_b (
    .clk_i   (clk_i),
    .we_i    (fe_we),
    .waddr_i (fe_waddr),
    .wdata_i (fe_wdata),
    .re_i    (fe_re),
    .raddr_i (fe_raddr_b),
    .rdata_o (fe_rdata_b)
  );

  // Operands of the running micro-op.
  logic [FW-1:0] a_op, b_op;
  logic [255:0]  a_ext, b_ext;
  assign a_op  = fe_rdata_a;
  assign b_op  = (uop.src_b == mxz_pkg::FE_K) ? mxz_pkg::A24 : fe_rdata_b;
  assign a_ext = {1'b0, a_op};
  assign b_ext = {1'b0, b_op};

  // Raw slot value reduced once into [0, p).
  logic [FW-1:0] raw_val, raw_canon;
  always_comb begin
    raw_val = {lram_rdata, asm_q[3], asm_q[2], asm_q[1], asm_q[0]};
    raw_canon = (raw_val >= mxz_pkg::PRIME) ? (raw_val - mxz_pkg::PRIME) : raw_val;
  end

  // Final conditional subtract of a folded value.
  logic [255:0] x_low, x_sub;
  logic [FW-1:0] x_canon;
  always_comb begin
    x_low   = x_q[255:0];
    x_sub   = x_low - {1'b0, mxz_pkg::PRIME};
    x_canon = (x_low >= {1'b0, mxz_pkg::PRIME}) ? x_sub[FW-1:0] : x_low[FW-1:0];
  end

  // Product scanning: column k, row i, column j = k - i.
  logic [3:0]  j4, kn;
  logic [2:0]  j_idx, i_end, i_start_n;
  logic        col_end, last_col;
  logic [31:0] a_w, b_w;
  logic [71:0] acc_sum;
  always_comb begin
    j4        = k_q - {1'b0, i_q};
    j_idx     = j4[2:0];
    kn        = k_q + 4'd1;
    i_end     = (k_q < 4'd8) ? k_q[2:0] : 3'd7;
    i_start_n = (kn < 4'd8) ? 3'd0 : 3'(kn - 4'd7);
    col_end   = (i_q == i_end);
    last_col  = (k_q == 4'd14);
    a_w       = a_ext[{i_q, 5'b00000} +: 32];
    b_w       = b_ext[{j_idx, 5'b00000} +: 32];
    acc_sum   = acc_q + {8'd0, p_q};
  end

  // Register file port control.
  always_comb begin
    fe_we      = 1'b0;
    fe_waddr   = uop.dst;
    fe_wdata   = x_canon;
    fe_re      = 1'b0;
    fe_raddr_a = uop.src_a;
    fe_raddr_b = uop.src_b;
    unique case (state_q)
      S_LOAD: begin
        fe_we    = ld_vld_q && (ld_limb_q == LAST_LIMB);
        fe_waddr = {1'b0, ld_slot_q};
        fe_wdata = raw_canon;
      end
      S_FETCH: begin
        fe_re = 1'b1;
      end
      S_WB: begin
        fe_we = 1'b1;
      end
      S_EFETCH: begin
        fe_re      = 1'b1;
        fe_raddr_a = mxz_pkg::FE_RU;
        fe_raddr_b = mxz_pkg::FE_RW;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire && (in_op == mxz_pkg::OP_ADD || in_op == mxz_pkg::OP_DBL)) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (ld_vld_q && ld_slot_q == LAST_SLOT && ld_limb_q == LAST_LIMB) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH:  state_d = (uop.kind == mxz_pkg::UOP_MUL) ? S_MUL : S_ARITH;
      S_ARITH:  state_d = S_FOLD;
      S_MUL: begin
        if (col_end && last_col) begin
          state_d = S_MDRAIN;
        end
      end
      S_MDRAIN: state_d = S_MTAIL;
      S_MTAIL:  state_d = S_RED;
      S_RED: begin
        if (red_cnt_q == 2'd2) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        if (fold_cnt_q) begin
          state_d = S_WB;
        end
      end
      S_WB:     state_d = uop.last ? S_EFETCH : S_FETCH;
      S_EFETCH: state_d = S_ELOAD;
      S_ELOAD:  state_d = S_EMIT;
      S_EMIT: begin
        if (m_fire && em_coord_q && em_limb_q == LAST_LIMB) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pc_q       <= mxz_pkg::PC_ADD;
      iss_slot_q <= '0;
      iss_limb_q <= '0;
      iss_on_q   <= 1'b0;
      ld_vld_q   <= 1'b0;
      ld_slot_q  <= '0;
      ld_limb_q  <= '0;
      k_q        <= '0;
      i_q        <= '0;
      p_vld_q    <= 1'b0;
      p_end_q    <= 1'b0;
      red_cnt_q  <= '0;
      fold_cnt_q <= 1'b0;
      em_coord_q <= 1'b0;
      em_limb_q  <= '0;
    end else begin
      state_q  <= state_d;
      ld_vld_q <= lram_re;
      p_vld_q  <= (state_q == S_MUL);
      p_end_q  <= col_end;
      if (lram_re) begin
        ld_slot_q <= iss_slot_q;
        ld_limb_q <= iss_limb_q;
      end
      // Start of a command.
      if (state_q == S_IDLE && s_fire) begin
        pc_q       <= (in_op == mxz_pkg::OP_ADD) ? mxz_pkg::PC_ADD : mxz_pkg::PC_DBL;
        iss_slot_q <= '0;
        iss_limb_q <= '0;
        iss_on_q   <= 1'b1;
      end
      // Slot read-in, limb by limb over all six slots.
      if (lram_re) begin
        if (iss_limb_q == LAST_LIMB) begin
          iss_limb_q <= '0;
          if (iss_slot_q == LAST_SLOT) begin
            iss_on_q <= 1'b0;
          end else begin
            iss_slot_q <= iss_slot_q + 3'd1;
          end
        end else begin
          iss_limb_q <= iss_limb_q + 3'd1;
        end
      end
      // Multiply loop indices.
      if (state_q == S_FETCH) begin
        k_q <= '0;
        i_q <= '0;
      end else if (state_q == S_MUL) begin
        if (col_end) begin
          k_q <= kn;
          i_q <= i_start_n;
        end else begin
          i_q <= i_q + 3'd1;
        end
      end
      red_cnt_q  <= (state_q == S_RED) ? red_cnt_q + 2'd1 : 2'd0;
      fold_cnt_q <= (state_q == S_FOLD) ? !fold_cnt_q : 1'b0;
      if (state_q == S_WB && !uop.last) begin
        pc_q <= pc_q + 5'd1;
      end
      // Result limb counters.
      if (state_q == S_ELOAD) begin
        em_coord_q <= 1'b0;
        em_limb_q  <= '0;
      end else if (m_fire) begin
        if (em_limb_q == LAST_LIMB) begin
          em_limb_q  <= '0;
          em_coord_q <= 1'b1;
        end else begin
          em_limb_q <= em_limb_q + 3'd1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    // Limb assembly for the slot read-in.
    if (ld_vld_q) begin
      asm_q[3] <= lram_rdata;
      asm_q[2] <= asm_q[3];
      asm_q[1] <= asm_q[2];
      asm_q[0] <= asm_q[1];
    end
    // Multiplier stage.
    if (state_q == S_MUL) begin
      p_q <= a_w * b_w;
    end
    // Column accumulator and product word shifter.
    if (state_q == S_FETCH) begin
      acc_q <= '0;
    end else if (p_vld_q) begin
      if (p_end_q) begin
        t_q   <= {acc_sum[31:0], t_q[511:32]};
        acc_q <= acc_sum >> 32;
      end else begin
        acc_q <= acc_sum;
      end
    end else if (state_q == S_MTAIL) begin
      t_q <= {acc_q[31:0], t_q[511:32]};
    end
    // Wide adder: add, subtract, reduction by 38 and folding by 19.
    unique case (state_q)
      S_ARITH: begin
        if (uop.kind == mxz_pkg::UOP_ADD) begin
          x_q <= {7'd0, a_op} + {7'd0, b_op};
        end else begin
          x_q <= {7'd0, a_op} + {7'd0, mxz_pkg::PRIME} - {7'd0, b_op};
        end
      end
      S_RED: begin
        case (red_cnt_q)
          2'd0:    x_q <= {6'd0, t_q[255:0]} + ({6'd0, t_q[511:256]} << 5);
          2'd1:    x_q <= x_q + ({6'd0, t_q[511:256]} << 2);
          default: x_q <= x_q + ({6'd0, t_q[511:256]} << 1);
        endcase
      end
      S_FOLD: begin
        x_q <= {7'd0, x_q[FW-1:0]} + XW'(x_q[XW-1:FW]) * XW'(19);
      end
      default: begin
      end
    endcase
    // Result shifter.
    if (state_q == S_ELOAD) begin
      out_sr_q <= {fe_rdata_b, fe_rdata_a};
    end else if (m_fire) begin
      out_sr_q <= out_sr_q >> LW;
    end
  end

  // Ports.
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_EMIT);
  assign m_axis_tdata_o  = {2'b00, out_sr_q[LW-1:0], em_limb_q};
  assign m_axis_tuser_o  = em_coord_q;
  assign m_axis_tlast_o  = em_coord_q && (em_limb_q == LAST_LIMB);

  // Assertions.
  `ASSERT_PROP(a_out_blocks_in, clk_i, rst_ni, m_axis_tvalid_o |-> !s_axis_tready_o, "item accepted while a result limb is pending")
  `ASSERT_PROP(a_cmd_busy, clk_i, rst_ni, (s_fire && (in_op == mxz_pkg::OP_ADD || in_op == mxz_pkg::OP_DBL)) |=> !s_axis_tready_o, "still ready after a compute command")
  `ASSERT_NEVER(a_no_const_write, clk_i, rst_ni, fe_we && (fe_waddr == mxz_pkg::FE_K), "write to the constant entry")
  `ASSERT_PROP(a_idle_after_last, clk_i, rst_ni, (m_fire && m_axis_tlast_o) |=> s_axis_tready_o, "not idle after the final limb")

endmodule
